// File: hdl/fbfl_pkg.sv
// ---------------------------------------------------------------------------
// Fixed-block free-list allocator: shared definitions
// Field widths, codes, sequencer states and parameter defaults.
// ---------------------------------------------------------------------------
`default_nettype none

package fbfl_pkg;

  localparam int MAX_BLOCKS_DEF      = 255;
  localparam int MAX_BLOCK_BYTES_DEF = 256;

  localparam int ACTION_W = 2;
  localparam int OFFSET_W = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 8;
  localparam int INDEX_W  = 8;
  localparam int SIZE_W   = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;
  localparam int PROD_W   = INDEX_W + SIZE_W;

  localparam logic [SIZE_W-1:0]  SIZE_RESET  = 9'd8;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 8'd255;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'd1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_INIT  = 2'd2
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_INVALID = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALLOC_RD,
    S_ALLOC_WB,
    S_FREE_MUL,
    S_FREE_CHK,
    S_FREE_DIV,
    S_FREE_WR,
    S_INIT,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// File: hdl/fbfl_req_if.sv
// ---------------------------------------------------------------------------
// Allocator request channel
// Valid/ready channel carrying the action and the byte offset to free.
// ---------------------------------------------------------------------------
`default_nettype none

interface fbfl_req_if;
  logic                            valid;
  logic                            ready;
  logic [fbfl_pkg::ACTION_W-1:0]   action;
  logic [fbfl_pkg::OFFSET_W-1:0]   byte_offset;

  modport source (output valid, action, byte_offset, input ready);
  modport sink   (input valid, action, byte_offset, output ready);
endinterface

`default_nettype wire

// File: hdl/fbfl_rsp_if.sv
// ---------------------------------------------------------------------------
// Allocator response channel
// Valid/ready channel carrying status, allocated offset and free count.
// ---------------------------------------------------------------------------
`default_nettype none

interface fbfl_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [fbfl_pkg::STATUS_W-1:0]   status;
  logic [fbfl_pkg::OFFSET_W-1:0]   block_offset;
  logic [fbfl_pkg::COUNT_W-1:0]    free_count;

  modport source (output valid, status, block_offset, free_count, input ready);
  modport sink   (input valid, status, block_offset, free_count, output ready);
endinterface

`default_nettype wire

// File: hdl/fixed_block_free_list_allocator.sv
// ---------------------------------------------------------------------------
// Fixed-block free-list allocator
// Hands out and takes back equal blocks of a chunk through a linked free list.
// ---------------------------------------------------------------------------
// Usage:
//   req carries one request: action (allocate, free, rebuild the list) and,
//   for a free, the byte offset of the block. rsp returns one response per
//   request: status, the allocated byte offset and the free count afterwards.
//   block_size and block_count are set through the cfg_* write port; the user
//   must write them only while the block is idle, as the block does not
//   enforce it. A rebuild request uses block_count to relink the list.
// Sequence (request accepted to response valid): allocate: link read,
//   head update, response load; free: range check, then the 16-step
//   restoring divider that turns the offset into a block index, one quotient
//   bit a cycle, then the link write (an offset outside the chunk goes from
//   the check to the response); rebuild: one link write a cycle; an unused
//   action or an allocate with nothing free goes straight to the response.
// One request is worked on at a time; req.ready is high only when the
// sequencer is idle. A finished response sits in the rsp output register;
// the next request may be accepted meanwhile, and its response holds in
// the sequencer until rsp frees up, so a stalled receiver stalls the block.
// Reset clears the free count and head; the link store holds nothing valid
// until a rebuild request has run.
// ---------------------------------------------------------------------------
`default_nettype none

module fixed_block_free_list_allocator #(
  parameter int MAX_BLOCKS      = fbfl_pkg::MAX_BLOCKS_DEF,
  parameter int MAX_BLOCK_BYTES = fbfl_pkg::MAX_BLOCK_BYTES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_wr_en,
  input  wire logic [fbfl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [fbfl_pkg::CFG_DATA_W-1:0]   cfg_data,
  fbfl_req_if.sink                               req,
  fbfl_rsp_if.source                             rsp
);

  localparam int AW = $clog2(MAX_BLOCKS);

  // Configuration registers
  logic [fbfl_pkg::SIZE_W-1:0]  block_size;
  logic [fbfl_pkg::COUNT_W-1:0] block_count;

  // Effective (clamped) configuration
  logic [fbfl_pkg::SIZE_W-1:0]  size_eff;
  logic [fbfl_pkg::COUNT_W-1:0] count_eff;

  // Sequencer and datapath state
  fbfl_pkg::state_t state, state_next;
  logic [fbfl_pkg::INDEX_W-1:0]  head_index;
  logic [fbfl_pkg::COUNT_W-1:0]  free_blocks;
  logic [fbfl_pkg::OFFSET_W-1:0] offset;
  logic [fbfl_pkg::PROD_W-1:0]   prod;
  logic [fbfl_pkg::SIZE_W-1:0]   rem;
  logic [fbfl_pkg::OFFSET_W-1:0] quo;
  logic [3:0]                    bit_cnt;
  logic [fbfl_pkg::COUNT_W-1:0]  walk_cnt;
  fbfl_pkg::status_t             res_status;
  logic [fbfl_pkg::OFFSET_W-1:0] res_offset;

  // Output register
  logic                          rsp_valid;
  logic [fbfl_pkg::STATUS_W-1:0] rsp_status;
  logic [fbfl_pkg::OFFSET_W-1:0] rsp_offset;
  logic [fbfl_pkg::COUNT_W-1:0]  rsp_free;

  // Control strobes
  logic accept;
  logic rsp_load;
  logic head_oob;

  // Shared multiplier and divider step
  logic [fbfl_pkg::INDEX_W-1:0]  mul_a;
  logic [fbfl_pkg::SIZE_W:0]     div_shift;
  logic                          div_ge;

  // Link store ports
  logic                          ram_wr_en;
  logic [AW-1:0]                 ram_wr_addr;
  logic [fbfl_pkg::INDEX_W-1:0]  ram_wr_data;
  logic                          ram_rd_en;
  logic [fbfl_pkg::INDEX_W-1:0]  ram_rd_data;

  // ---- configuration -------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      block_size  <= fbfl_pkg::SIZE_RESET;
      block_count <= fbfl_pkg::COUNT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        fbfl_pkg::REG_BLOCK_SIZE:  block_size  <= cfg_data;
        fbfl_pkg::REG_BLOCK_COUNT: block_count <= cfg_data[fbfl_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero size acts as one byte; oversize values clamp to the limits.
  always_comb begin
    priority if (block_size == '0) begin
      size_eff = fbfl_pkg::SIZE_W'(1);
    end else if (block_size > fbfl_pkg::SIZE_W'(MAX_BLOCK_BYTES)) begin
      size_eff = fbfl_pkg::SIZE_W'(MAX_BLOCK_BYTES);
    end else begin
      size_eff = block_size;
    end
    if (block_count > fbfl_pkg::COUNT_W'(MAX_BLOCKS)) begin
      count_eff = fbfl_pkg::COUNT_W'(MAX_BLOCKS);
    end else begin
      count_eff = block_count;
    end
  end

  // ---- shared arithmetic ---------------------------------------------------
  // Multiplier: head * size on allocate, count * size for the free range check.
  assign mul_a     = (state == fbfl_pkg::S_ALLOC_RD) ? head_index : count_eff;
  assign div_shift = {rem, quo[fbfl_pkg::OFFSET_W-1]};
  assign div_ge    = div_shift >= {1'b0, size_eff};
  // A head beyond the store reads as link zero.
  assign head_oob  = head_index >= fbfl_pkg::INDEX_W'(MAX_BLOCKS);

  // ---- sequencer -----------------------------------------------------------
  assign accept   = req.valid && req.ready;
  assign req.ready = (state == fbfl_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fbfl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    rsp_load    = 1'b0;
    ram_wr_en   = 1'b0;
    ram_wr_addr = walk_cnt[AW-1:0];
    ram_wr_data = walk_cnt + 1'b1;
    ram_rd_en   = 1'b0;
    unique case (state)
      fbfl_pkg::S_IDLE: begin
        if (accept) begin
          unique case (req.action)
            fbfl_pkg::ACT_ALLOC:
              state_next = (free_blocks == '0) ? fbfl_pkg::S_DONE : fbfl_pkg::S_ALLOC_RD;
            fbfl_pkg::ACT_FREE: state_next = fbfl_pkg::S_FREE_MUL;
            fbfl_pkg::ACT_INIT: state_next = fbfl_pkg::S_INIT;
            default:            state_next = fbfl_pkg::S_DONE;
          endcase
        end
      end
      fbfl_pkg::S_ALLOC_RD: begin
        ram_rd_en  = 1'b1;
        state_next = fbfl_pkg::S_ALLOC_WB;
      end
      fbfl_pkg::S_ALLOC_WB: state_next = fbfl_pkg::S_DONE;
      fbfl_pkg::S_FREE_MUL: state_next = fbfl_pkg::S_FREE_CHK;
      fbfl_pkg::S_FREE_CHK: begin
        if ({1'b0, offset} >= prod) begin
          state_next = fbfl_pkg::S_DONE;
        end else begin
          state_next = fbfl_pkg::S_FREE_DIV;
        end
      end
      fbfl_pkg::S_FREE_DIV: begin
        if (bit_cnt == 4'd15) begin
          state_next = fbfl_pkg::S_FREE_WR;
        end
      end
      fbfl_pkg::S_FREE_WR: begin
        // Push the freed block: its link takes the old head.
        ram_wr_en   = 1'b1;
        ram_wr_addr = quo[AW-1:0];
        ram_wr_data = head_index;
        state_next  = fbfl_pkg::S_DONE;
      end
      fbfl_pkg::S_INIT: begin
        if (walk_cnt < count_eff) begin
          ram_wr_en = 1'b1;
        end else begin
          state_next = fbfl_pkg::S_DONE;
        end
      end
      fbfl_pkg::S_DONE: begin
        if (!rsp_valid || rsp.ready) begin
          rsp_load   = 1'b1;
          state_next = fbfl_pkg::S_IDLE;
        end
      end
      default: state_next = fbfl_pkg::S_IDLE;
    endcase
  end

  // ---- datapath control state ---------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      head_index  <= '0;
      free_blocks <= '0;
    end else begin
      unique case (state)
        fbfl_pkg::S_ALLOC_WB: begin
          head_index  <= head_oob ? '0 : ram_rd_data;
          free_blocks <= free_blocks - 1'b1;
        end
        fbfl_pkg::S_FREE_WR: begin
          head_index <= quo[fbfl_pkg::INDEX_W-1:0];
          if (free_blocks < fbfl_pkg::COUNT_W'(MAX_BLOCKS)) begin
            free_blocks <= free_blocks + 1'b1;
          end
        end
        fbfl_pkg::S_INIT: begin
          if (walk_cnt >= count_eff) begin
            head_index  <= '0;
            free_blocks <= count_eff;
          end
        end
        default: ;
      endcase
    end
  end

  // ---- datapath payload ----------------------------------------------------
  always_ff @(posedge clk) begin
    prod <= fbfl_pkg::PROD_W'(mul_a) * fbfl_pkg::PROD_W'(size_eff);
    unique case (state)
      fbfl_pkg::S_IDLE: begin
        offset     <= req.byte_offset;
        walk_cnt   <= '0;
        res_offset <= '0;
        if (req.action == fbfl_pkg::ACT_ALLOC && free_blocks == '0) begin
          res_status <= fbfl_pkg::STAT_EMPTY;
        end else begin
          res_status <= fbfl_pkg::STAT_OK;
        end
      end
      fbfl_pkg::S_ALLOC_WB: res_offset <= prod[fbfl_pkg::OFFSET_W-1:0];
      fbfl_pkg::S_FREE_CHK: begin
        rem     <= '0;
        quo     <= offset;
        bit_cnt <= '0;
        if ({1'b0, offset} >= prod) begin
          res_status <= fbfl_pkg::STAT_INVALID;
        end
      end
      fbfl_pkg::S_FREE_DIV: begin
        // One restoring division step: shift in a dividend bit, subtract if it fits.
        rem     <= div_ge ? fbfl_pkg::SIZE_W'(div_shift - {1'b0, size_eff})
                          : div_shift[fbfl_pkg::SIZE_W-1:0];
        quo     <= {quo[fbfl_pkg::OFFSET_W-2:0], div_ge};
        bit_cnt <= bit_cnt + 1'b1;
      end
      fbfl_pkg::S_INIT: walk_cnt <= walk_cnt + 1'b1;
      default: ;
    endcase
  end

  // ---- link store ----------------------------------------------------------
  fbfl_ram #(
    .WIDTH (fbfl_pkg::INDEX_W),
    .DEPTH (MAX_BLOCKS)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (head_index[AW-1:0]),
    .rd_data (ram_rd_data)
  );

  // ---- response register ---------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_status <= res_status;
      rsp_offset <= res_offset;
      rsp_free   <= free_blocks;
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.status       = rsp_status;
  assign rsp.block_offset = rsp_offset;
  assign rsp.free_count   = rsp_free;

  // ---- assertions ----------------------------------------------------------
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_blocks <= fbfl_pkg::COUNT_W'(MAX_BLOCKS))
    else $error("free count above block limit");

  a_quo_fits: assert property (@(posedge clk) disable iff (rst)
    state == fbfl_pkg::S_FREE_WR |-> quo[fbfl_pkg::OFFSET_W-1:fbfl_pkg::INDEX_W] == '0)
    else $error("freed block index does not fit");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    ram_wr_en && state == fbfl_pkg::S_INIT |-> walk_cnt < fbfl_pkg::COUNT_W'(MAX_BLOCKS))
    else $error("list rebuild writes beyond the link store");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_load && res_status != fbfl_pkg::STAT_OK |=> rsp_offset == '0)
    else $error("failed request returned a block offset");

endmodule

`default_nettype wire

// File: hdl/fbfl_ram.sv
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module fbfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 255
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
